/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the concurrent checks of the suppression block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SGBS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SGBS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sgbs_pkg.sv */
// ----------------------------------------------------------------------------
// sgbs_pkg
// Types, sizes and codes shared by the box suppression controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sgbs_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W     = $clog2(MAX_BOXES);
   localparam int CNT_W     = $clog2(MAX_BOXES + 1);
   localparam int THR_W     = 16;
   localparam int AREA_W    = 32;
   localparam int UNION_W   = AREA_W + 1;
   localparam int PROD_W    = THR_W + UNION_W;

   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   // First field in the highest bits.
   typedef struct packed {
      logic [7:0]         class_label;
      logic [15:0]        confidence;
      logic [15:0]        box_height;
      logic [15:0]        box_width;
      logic signed [15:0] corner_y;
      logic signed [15:0] corner_x;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RANK_HEAD,
      ST_RANK_LOAD,
      ST_RANK_SCAN,
      ST_RANK_DRAIN,
      ST_RANK_WRITE,
      ST_NMS_HEAD,
      ST_NMS_ORD,
      ST_NMS_LOAD,
      ST_NMS_SCAN,
      ST_NMS_DRAIN,
      ST_NMS_DECIDE,
      ST_EMIT_HEAD,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic             box_we;
      logic [IDX_W-1:0] box_waddr;
      logic             box_rd_ord;
      logic [IDX_W-1:0] box_raddr;
      logic [IDX_W-1:0] ord_raddr;
      logic             ord_we;
      logic [IDX_W-1:0] rank_self;
      logic             load_cand;
      logic             rank_issue;
      logic             iou_issue;
      logic [IDX_W-1:0] kept_raddr;
      logic             kept_we;
      logic [IDX_W-1:0] kept_waddr;
      logic             rsp_load;
      logic             rsp_last;
      logic             rsp_ovf;
   } cmd_type;

   typedef struct packed {
      logic iou_busy;
      logic suppress;
      logic rsp_taken;
   } status_type;

endpackage

`default_nettype wire

/* rtl/sgbs_ram.sv */
// ----------------------------------------------------------------------------
// sgbs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sgbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/sgbs_ctrl.sv */
// ----------------------------------------------------------------------------
// sgbs_ctrl
// Sequencer for loading, ranking, greedy suppression and emitting of boxes.
// ----------------------------------------------------------------------------
`default_nettype none

module sgbs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tlast,
   output logic                       req_tready,
   output sgbs_pkg::cmd_type          cmd,
   input  wire sgbs_pkg::status_type  status
);

   import sgbs_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] kc_ff, kc_in;
   logic             ovf_ff, ovf_in;
   logic             accept;
   logic [CNT_W-1:0] n_last;
   logic [CNT_W-1:0] kc_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         n_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         kc_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         kc_ff    <= kc_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign n_last  = n_ff - CNT_W'(1);
   assign kc_last = kc_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      kc_in    = kc_ff;
      ovf_in   = ovf_ff;
      req_tready = 1'b0;
      accept     = 1'b0;
      cmd = '0;
      cmd.box_waddr  = n_ff[IDX_W-1:0];
      cmd.box_raddr  = i_ff[IDX_W-1:0];
      cmd.ord_raddr  = i_ff[IDX_W-1:0];
      cmd.rank_self  = i_ff[IDX_W-1:0];
      cmd.kept_raddr = j_ff[IDX_W-1:0];
      cmd.kept_waddr = kc_ff[IDX_W-1:0];
      cmd.rsp_last   = (j_ff == kc_last);
      cmd.rsp_ovf    = ovf_ff;

      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               if (n_ff < CNT_W'(MAX_BOXES)) begin
                  cmd.box_we = 1'b1;
                  n_in       = n_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  i_in     = '0;
                  state_in = ST_RANK_HEAD;
               end
            end
         end
         ST_RANK_HEAD: begin
            state_in = ST_RANK_LOAD;
         end
         ST_RANK_LOAD: begin
            cmd.load_cand = 1'b1;
            j_in          = '0;
            state_in      = ST_RANK_SCAN;
         end
         ST_RANK_SCAN: begin
            cmd.box_raddr  = j_ff[IDX_W-1:0];
            cmd.rank_issue = 1'b1;
            j_in           = j_ff + CNT_W'(1);
            if (j_ff == n_last) begin
               state_in = ST_RANK_DRAIN;
            end
         end
         ST_RANK_DRAIN: begin
            state_in = ST_RANK_WRITE;
         end
         ST_RANK_WRITE: begin
            cmd.ord_we = 1'b1;
            if (i_ff == n_last) begin
               i_in     = '0;
               state_in = ST_NMS_HEAD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_RANK_HEAD;
            end
         end
         ST_NMS_HEAD: begin
            state_in = ST_NMS_ORD;
         end
         ST_NMS_ORD: begin
            cmd.box_rd_ord = 1'b1;
            state_in       = ST_NMS_LOAD;
         end
         ST_NMS_LOAD: begin
            cmd.load_cand = 1'b1;
            j_in          = '0;
            state_in      = (kc_ff == '0) ? ST_NMS_DECIDE : ST_NMS_SCAN;
         end
         ST_NMS_SCAN: begin
            cmd.iou_issue = 1'b1;
            j_in          = j_ff + CNT_W'(1);
            if (j_ff == kc_last) begin
               state_in = ST_NMS_DRAIN;
            end
         end
         ST_NMS_DRAIN: begin
            if (!status.iou_busy) begin
               state_in = ST_NMS_DECIDE;
            end
         end
         ST_NMS_DECIDE: begin
            if (!status.suppress) begin
               cmd.kept_we = 1'b1;
               kc_in       = kc_ff + CNT_W'(1);
            end
            if (i_ff == n_last) begin
               j_in     = '0;
               state_in = ST_EMIT_HEAD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_NMS_HEAD;
            end
         end
         ST_EMIT_HEAD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (status.rsp_taken) begin
               if (j_ff == kc_last) begin
                  n_in     = '0;
                  kc_in    = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_EMIT_HEAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/sgbs_dp.sv */
// ----------------------------------------------------------------------------
// sgbs_dp
// Box stores, score ranking compare, overlap test pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgbs_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [sgbs_pkg::THR_W-1:0]    csr_wdata,
   input  wire sgbs_pkg::box_type             req_box,
   input  wire sgbs_pkg::cmd_type             cmd,
   output sgbs_pkg::status_type               status,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output sgbs_pkg::box_type                  rsp_box,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser
);

   import sgbs_pkg::*;

   logic [THR_W-1:0]   thr_ff;
   logic [BOX_W-1:0]   box_rdata;
   logic [BOX_W-1:0]   kept_rdata;
   logic [IDX_W-1:0]   ord_rdata;
   logic [IDX_W-1:0]   box_raddr;
   box_type            rd_box;
   box_type            kb;
   box_type            cand_ff;
   logic [IDX_W-1:0]   rank_ff;
   logic               rank_v_ff;
   logic [IDX_W-1:0]   rank_j_ff;
   logic               beats;

   logic               v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [15:0]        iw_ff, ih_ff, bw_ff, bh_ff;
   logic [AREA_W-1:0]  area_a_ff, area_b_ff, inter2_ff, inter3_ff, inter4_ff;
   logic [UNION_W-1:0] uni_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               suppress_ff;

   logic signed [17:0] al, ar, at, ab, bl, br, bt, bb;
   logic signed [17:0] lft, rgt, top, btm;
   logic signed [18:0] ow, oh;
   logic [15:0]        iw, ih;
   logic [PROD_W-1:0]  scaled;

   box_type            rsp_box_ff;
   logic               rsp_valid_ff, rsp_last_ff, rsp_ovf_ff;
   logic               taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign box_raddr = cmd.box_rd_ord ? ord_rdata : cmd.box_raddr;

   sgbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock (clock),
      .we    (cmd.box_we),
      .waddr (cmd.box_waddr),
      .wdata (req_box),
      .raddr (box_raddr),
      .rdata (box_rdata)
   );

   sgbs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_ord_ram (
      .clock (clock),
      .we    (cmd.ord_we),
      .waddr (rank_ff),
      .wdata (cmd.rank_self),
      .raddr (cmd.ord_raddr),
      .rdata (ord_rdata)
   );

   sgbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_kept_ram (
      .clock (clock),
      .we    (cmd.kept_we),
      .waddr (cmd.kept_waddr),
      .wdata (cand_ff),
      .raddr (cmd.kept_raddr),
      .rdata (kept_rdata)
   );

   assign rd_box = box_type'(box_rdata);
   assign kb     = box_type'(kept_rdata);

   // Rank of the held box: earlier boxes win ties, so the order is stable.
   assign beats = (rd_box.confidence > cand_ff.confidence) ||
                  ((rd_box.confidence == cand_ff.confidence) && (rank_j_ff < cmd.rank_self));

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_v_ff <= 1'b0;
      end else begin
         rank_v_ff <= cmd.rank_issue;
      end
      rank_j_ff <= cmd.box_raddr;
      if (cmd.load_cand) begin
         cand_ff <= rd_box;
         rank_ff <= '0;
      end else if (rank_v_ff && beats) begin
         rank_ff <= rank_ff + IDX_W'(1);
      end
   end

   // Intersection edges, exact in 18-bit signed arithmetic.
   always_comb begin
      al  = 18'(cand_ff.corner_x);
      at  = 18'(cand_ff.corner_y);
      ar  = al + $signed({2'b00, cand_ff.box_width});
      ab  = at + $signed({2'b00, cand_ff.box_height});
      bl  = 18'(kb.corner_x);
      bt  = 18'(kb.corner_y);
      br  = bl + $signed({2'b00, kb.box_width});
      bb  = bt + $signed({2'b00, kb.box_height});
      lft = (al > bl) ? al : bl;
      top = (at > bt) ? at : bt;
      rgt = (ar < br) ? ar : br;
      btm = (ab < bb) ? ab : bb;
      ow  = 19'(rgt) - 19'(lft);
      oh  = 19'(btm) - 19'(top);
      iw  = (ow > 19'sd0) ? ow[15:0] : 16'd0;
      ih  = (oh > 19'sd0) ? oh[15:0] : 16'd0;
   end

   assign scaled = PROD_W'({inter4_ff, 16'd0});

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.iou_issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      area_a_ff <= cand_ff.box_width * cand_ff.box_height;
      iw_ff     <= iw;
      ih_ff     <= ih;
      bw_ff     <= kb.box_width;
      bh_ff     <= kb.box_height;
      inter2_ff <= iw_ff * ih_ff;
      area_b_ff <= bw_ff * bh_ff;
      inter3_ff <= inter2_ff;
      uni_ff    <= UNION_W'(area_a_ff) + UNION_W'(area_b_ff) - UNION_W'(inter2_ff);
      inter4_ff <= inter3_ff;
      prod_ff   <= PROD_W'(thr_ff) * PROD_W'(uni_ff);
      if (cmd.load_cand) begin
         suppress_ff <= 1'b0;
      end else if (v4_ff && (scaled > prod_ff)) begin
         suppress_ff <= 1'b1;
      end
   end

   assign status.iou_busy  = v0_ff | v1_ff | v2_ff | v3_ff | v4_ff;
   assign status.suppress  = suppress_ff;
   assign status.rsp_taken = taken;

   assign taken = rsp_valid_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (taken) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_box_ff  <= kb;
         rsp_last_ff <= cmd.rsp_last;
         rsp_ovf_ff  <= cmd.rsp_ovf;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_box    = rsp_box_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

/* rtl/sorted_greedy_box_suppression.sv */
// ----------------------------------------------------------------------------
// sorted_greedy_box_suppression
// Score-ordered greedy non-maximum suppression over a stored set of boxes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                  Beat ends
//   req_*     in         one candidate box, tlast = final box     tvalid & tready
//   rsp_*     out        one kept box, tlast = last kept box      tvalid & tready
//   csr_*     in         overlap threshold, unsigned Q0.16        csr_we
//
// Loading accepts one box per cycle. After the final box, ranking compares
// each box with every box of the set. Suppression tests each box, in rank
// order, against the k already kept boxes (one compare issue per kept box and
// a drain of the overlap pipeline). Both are paced by the single read port of
// the box and kept-box memories. Each result beat is loaded only after the
// previous one has been taken. No input is taken while a set is ranked,
// suppressed or emitted. Reset is synchronous, active high, and restores
// the threshold to 29491; the memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_greedy_box_suppression (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Threshold register write.
   input  wire logic                         csr_we,
   input  wire logic [sgbs_pkg::THR_W-1:0]   csr_wdata,
   // Candidate boxes.
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // corner_x, corner_y, box_width, box_height, confidence, class_label
   input  wire logic [sgbs_pkg::BOX_W-1:0]   req_tdata,
   input  wire logic                         req_tlast,
   // Kept boxes.
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // kept_x, kept_y, kept_width, kept_height, kept_score, kept_class
   output logic [sgbs_pkg::BOX_W-1:0]        rsp_tdata,
   output logic                              rsp_tlast,
   // dropped_overflow
   output logic                              rsp_tuser
);

   import sgbs_pkg::*;

   cmd_type    cmd;
   status_type status;
   box_type    rsp_box;

   // The controller owns the index counters and sequencing; the datapath holds the
   // memories, the rank counter, the compare logic and the output register.
   sgbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sgbs_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_box    (box_type'(req_tdata)),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_box    (rsp_box),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign rsp_tdata = BOX_W'(rsp_box);

   // Loading and emitting never overlap.
   `SGBS_ASSERT_IMP(a_no_load_while_emit, rsp_tvalid, !req_tready, "input open during emit")
   // The final box closes the input until the set has been emitted.
   `SGBS_ASSERT_NXT(a_final_closes_input, req_tvalid && req_tready && req_tlast, !req_tready,
                    "input still open after final box")
   // Nothing follows the last kept box of a set.
   `SGBS_ASSERT_NXT(a_last_ends_set, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid,
                    "result after last kept box")

endmodule

`default_nettype wire

/* test/tb_sorted_greedy_box_suppression.sv */
// ----------------------------------------------------------------------------
// tb_sorted_greedy_box_suppression
// Self-checking bench for the greedy box suppression block: drives sets of
// candidate boxes, predicts the kept boxes per set and compares each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_greedy_box_suppression;
   import sgbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A pending input beat: one box and its final-box flag.
   typedef struct {
      box_type box;
      logic    final_box;
   } cand_type;

   // One expected kept-box beat.
   typedef struct {
      box_type box;
      logic    last_kept;
      logic    dropped;
   } kept_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [THR_W-1:0]    csr_wdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [BOX_W-1:0]    req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [BOX_W-1:0]    rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tuser;

   cand_type   pending_boxes[$];
   kept_type   expected_kept[$];

   // Predictor state: the set being loaded and the threshold.
   box_type    set_store[$];
   logic       set_overflow;
   logic [15:0] iou_threshold;

   int         error_count;
   int         long_hold;

   int  gap_left;
   bit  req_tready_seen;
   int  stall_left;

   sorted_greedy_box_suppression u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // corner_x, corner_y, box_width, box_height,
                                 // confidence, class_label
      .req_tlast  (req_tlast),   // final_box
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // kept_x, kept_y, kept_width, kept_height,
                                 // kept_score, kept_class
      .rsp_tlast  (rsp_tlast),   // last_kept
      .rsp_tuser  (rsp_tuser)    // dropped_overflow
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // Overlap area of two boxes, in exact wide arithmetic.
   function automatic longint unsigned overlap_of(box_type a, box_type b);
      longint l, t, r, btm, ra, rb, ba, bb;
      l  = (a.corner_x > b.corner_x) ? a.corner_x : b.corner_x;
      t  = (a.corner_y > b.corner_y) ? a.corner_y : b.corner_y;
      ra = longint'(a.corner_x) + longint'(a.box_width);
      rb = longint'(b.corner_x) + longint'(b.box_width);
      ba = longint'(a.corner_y) + longint'(a.box_height);
      bb = longint'(b.corner_y) + longint'(b.box_height);
      r   = (ra < rb) ? ra : rb;
      btm = (ba < bb) ? ba : bb;
      if (r - l <= 0 || btm - t <= 0) return 0;
      return longint'(r - l) * longint'(btm - t);
   endfunction

   function automatic longint unsigned area_of_box(box_type a);
      return longint'(a.box_width) * longint'(a.box_height);
   endfunction

   // Accepts one box into the predicted set; on the final box, ranks the set by
   // score (stable), runs the greedy pass and queues the kept boxes.
   task automatic predict_suppression(cand_type c);
      box_type ranked[$];
      bit      keep_flag[$];
      int      pos, nkept, emitted;
      bit      keep;
      longint unsigned inter, uni;
      kept_type exp_beat;
      if (set_store.size() < MAX_BOXES) set_store.insert(set_store.size(), c.box);
      else set_overflow = 1'b1;
      if (!c.final_box) return;
      foreach (set_store[i]) begin
         pos = ranked.size();
         while (pos > 0 && ranked[pos-1].confidence < set_store[i].confidence) pos--;
         ranked.insert(pos, set_store[i]);
      end
      nkept = 0;
      foreach (ranked[i]) begin
         keep = 1'b1;
         for (int j = 0; j < i; j++) begin
            if (!keep_flag[j]) continue;
            inter = overlap_of(ranked[i], ranked[j]);
            uni = area_of_box(ranked[i]) + area_of_box(ranked[j]) - inter;
            if (inter * 65536 > longint'(iou_threshold) * uni) keep = 1'b0;
         end
         keep_flag.insert(keep_flag.size(), keep);
         if (keep) nkept++;
      end
      emitted = 0;
      foreach (ranked[i]) begin
         if (keep_flag[i]) begin
            emitted++;
            exp_beat.box       = ranked[i];
            exp_beat.last_kept = (emitted == nkept);
            exp_beat.dropped   = set_overflow;
            expected_kept.insert(expected_kept.size(), exp_beat);
         end
      end
      set_store.delete();
      set_overflow = 1'b0;
   endtask

   // Input driver: one pending box per beat, random gap before each.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready_seen) begin
         if (pending_boxes.size() > 0 && gap_left == 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_boxes[0].box;
            req_tlast  <= pending_boxes[0].final_box;
            pending_boxes.pop_front();
            gap_left   <= $urandom_range(0, 7);
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end
      end
   end

   // Monitor: handshake on the input side feeds the predictor, the output side
   // is compared against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         req_tready_seen <= 1'b1;
         predict_suppression('{box_type'(req_tdata), req_tlast});
      end else begin
         req_tready_seen <= 1'b0;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_kept.size() == 0) begin
               report_mismatch("kept box with no expectation");
            end else begin
               if (rsp_tdata !== expected_kept[0].box)
                  report_mismatch($sformatf("box %h expected %h", rsp_tdata,
                                            expected_kept[0].box));
               if (rsp_tlast !== expected_kept[0].last_kept)
                  report_mismatch("last_kept flag");
               if (rsp_tuser !== expected_kept[0].dropped)
                  report_mismatch("dropped_overflow flag");
               expected_kept.pop_front();
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (long_hold > 0) begin
         rsp_tready <= 1'b0;
         long_hold  <= long_hold - 1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_tready && rsp_tvalid) begin
         stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic box_type random_box();
      box_type b;
      b.corner_x   = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 600));
      b.corner_y   = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 600));
      b.box_width  = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400));
      b.box_height = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400));
      b.confidence = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 7)) : 16'($urandom);
      b.class_label = 8'($urandom);
      return b;
   endfunction

   task automatic queue_box(box_type b, logic fin);
      cand_type c;
      c.box       = b;
      c.final_box = fin;
      pending_boxes.insert(pending_boxes.size(), c);
   endtask

   // Waits until the block has returned every kept box of queued sets.
   task automatic wait_idle();
      while (pending_boxes.size() > 0 || req_tvalid || expected_kept.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      iou_threshold = value;
   endtask

   initial begin
      box_type b;
      int      set_len;
      logic [15:0] thr_steps[4];
      thr_steps = '{16'd0, 16'd65535, 16'd32768, 16'd13107};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      gap_left = 0;
      long_hold = 0;
      error_count = 0;
      set_overflow = 1'b0;
      iou_threshold = THR_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single box with extreme fields, identical boxes, ties,
      // zero-area boxes (empty union keeps), touching boxes.
      queue_box('{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000}, 1'b1);
      b = '{8'h01, 16'd100, 16'd160, 16'd160, 16'sd0, 16'sd0};
      queue_box(b, 1'b0);
      queue_box(b, 1'b0);
      b.corner_x = 16'sd160;
      queue_box(b, 1'b0);
      queue_box('{8'h00, 16'd0, 16'd0, 16'd0, 16'sd5, 16'sd5}, 1'b0);
      queue_box('{8'h00, 16'd0, 16'd0, 16'd0, 16'sd5, 16'sd5}, 1'b1);
      queue_box('{8'h80, 16'd500, 16'd0, 16'd50, -16'sd8, -16'sd8}, 1'b0);
      queue_box('{8'h7F, 16'd900, 16'd40, 16'd40, -16'sd4, -16'sd4}, 1'b0);
      queue_box('{8'h55, 16'd900, 16'd40, 16'd41, -16'sd4, -16'sd3}, 1'b1);
      wait_idle();

      // Overflow: more boxes than the store holds. A short set queued behind
      // it keeps the input offered while the output is held off for a long
      // stretch once the first result is waiting, so the input stalls.
      for (int i = 0; i < MAX_BOXES + 3; i++) queue_box(random_box(), i == MAX_BOXES + 2);
      for (int i = 0; i < 4; i++) queue_box(random_box(), i == 3);
      wait (rsp_tvalid);
      long_hold = 400;
      wait_idle();

      // Random sets under several thresholds, extremes included.
      foreach (thr_steps[k]) begin
         write_threshold(thr_steps[k]);
         for (int s = 0; s < 11; s++) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
            for (int i = 0; i < set_len; i++) queue_box(random_box(), i == set_len - 1);
         end
         wait_idle();
      end
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_kept.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

/* sorted_greedy_box_suppression.f */
+incdir+rtl
rtl/sgbs_pkg.sv
rtl/sgbs_ram.sv
rtl/sgbs_ctrl.sv
rtl/sgbs_dp.sv
rtl/sorted_greedy_box_suppression.sv
test/tb_sorted_greedy_box_suppression.sv
